>>> src/sfdc16_pkg.sv
// Shared constants, status codes, result word type and CRC byte update
// for the serial frame deframer. No dependencies.
package sfdc16_pkg;

  localparam logic [7:0]  HDR_BYTE        = 8'hE6;
  localparam logic [7:0]  TAIL_BYTE       = 8'h6E;
  localparam logic [15:0] DEFAULT_MAX_LEN = 16'd512;
  localparam logic [15:0] CRC_POLY_REFL   = 16'hA001;
  localparam logic [15:0] CRC_XOROUT      = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_VALID  = 2'd0,
    ST_CRC    = 2'd1,
    ST_TAIL   = 2'd2,
    ST_LENGTH = 2'd3
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] sequence_id;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    status_t     frame_status;
    logic        last_of_frame;
  } result_t;

  // CRC-16/MAXIM, reflected form, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> src/sfdc16_if.sv
// Valid/ready channel interfaces for the deframer: received byte stream in,
// result words out. Depends on nothing.
interface sfdc16_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfdc16_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [15:0] sequence_id;
  logic [7:0]  command_code;
  logic [15:0] payload_length;
  logic [1:0]  frame_status;
  logic        last_of_frame;

  modport source (output valid, output item_kind, output payload_byte, output sequence_id,
                  output command_code, output payload_length, output frame_status,
                  output last_of_frame, input ready);
  modport sink   (input valid, input item_kind, input payload_byte, input sequence_id,
                  input command_code, input payload_length, input frame_status,
                  input last_of_frame, output ready);
endinterface

>>> src/serial_frame_deframer_crc16.sv
// Serial frame deframer with CRC-16/MAXIM check: header hunt, field capture,
// payload pass-through, tail check. Depends on sfdc16_pkg and sfdc16_if.
// Throughput: one received byte per cycle; input stalls only when the two-entry
//   output queue is full. A word is registered and is on the output the cycle
//   after its byte is taken if the queue is empty; queued words go out first.
// Reset (rst, synchronous): hunting, held fields and CRC cleared, queue empty, limit 512.
module serial_frame_deframer_crc16 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  sfdc16_rx_if.sink            rx,
  sfdc16_item_if.source        items
);

  typedef enum logic [12:0] {
    PH_HUNT0     = 13'b0000000000001,
    PH_HUNT1     = 13'b0000000000010,
    PH_SEQ_HI    = 13'b0000000000100,
    PH_SEQ_LO    = 13'b0000000001000,
    PH_CMD       = 13'b0000000010000,
    PH_LEN_HI    = 13'b0000000100000,
    PH_LEN_LO    = 13'b0000001000000,
    PH_PAYLOAD   = 13'b0000010000000,
    PH_CRC_HI    = 13'b0000100000000,
    PH_CRC_LO    = 13'b0001000000000,
    PH_TAIL1     = 13'b0010000000000,
    PH_TAIL2_OK  = 13'b0100000000000,
    PH_TAIL2_BAD = 13'b1000000000000
  } phase_t;

  logic [15:0] max_len;
  phase_t      phase, phase_next;
  logic [15:0] held_sequence, seq_next;
  logic [7:0]  held_command, cmd_next;
  logic [15:0] held_length, len_next;
  logic [15:0] bytes_left, left_next;
  logic [15:0] running_crc, crc_next;
  logic [15:0] received_crc, rcrc_next;

  logic                 accept;
  logic                 emit;
  sfdc16_pkg::result_t  res_new;
  sfdc16_pkg::kind_t    res_kind;
  logic [7:0]           res_byte;
  sfdc16_pkg::status_t  res_status;
  logic [7:0]           b;
  logic [15:0]          crc_upd;
  logic [15:0]          len_cat;

  sfdc16_pkg::result_t  q0, q1;
  logic [1:0]           q_cnt;
  logic                 push, pop;

  assign b       = rx.rx_byte;
  assign accept  = rx.valid && rx.ready;
  assign crc_upd = sfdc16_pkg::crc_feed(running_crc, b);
  assign len_cat = {held_length[15:8], b};

  always_comb begin
    phase_next = phase;
    seq_next   = held_sequence;
    cmd_next   = held_command;
    len_next   = held_length;
    left_next  = bytes_left;
    crc_next   = running_crc;
    rcrc_next  = received_crc;
    emit       = 1'b0;
    res_kind   = sfdc16_pkg::KIND_PAYLOAD;
    res_byte   = 8'h00;
    res_status = sfdc16_pkg::ST_VALID;
    unique case (phase)
      PH_HUNT1: begin
        phase_next = (b == sfdc16_pkg::HDR_BYTE) ? PH_SEQ_HI : PH_HUNT0;
        crc_next   = 16'h0000;
      end
      PH_SEQ_HI: begin
        crc_next   = crc_upd;
        seq_next   = {b, 8'h00};
        phase_next = PH_SEQ_LO;
      end
      PH_SEQ_LO: begin
        crc_next   = crc_upd;
        seq_next   = {held_sequence[15:8], b};
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        crc_next   = crc_upd;
        cmd_next   = b;
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        crc_next   = crc_upd;
        len_next   = {b, 8'h00};
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        crc_next = crc_upd;
        len_next = len_cat;
        if (len_cat > max_len) begin
          // oversize frame: report and hunt again
          phase_next = PH_HUNT0;
          emit       = 1'b1;
          res_kind   = sfdc16_pkg::KIND_END;
          res_status = sfdc16_pkg::ST_LENGTH;
        end else begin
          left_next  = len_cat;
          phase_next = (len_cat == 16'h0000) ? PH_CRC_HI : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_next  = crc_upd;
        left_next = bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          phase_next = PH_CRC_HI;
        end
        emit     = 1'b1;
        res_byte = b;
      end
      PH_CRC_HI: begin
        rcrc_next  = {b, 8'h00};
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rcrc_next  = {received_crc[15:8], b};
        phase_next = PH_TAIL1;
      end
      PH_TAIL1: begin
        phase_next = (b == sfdc16_pkg::TAIL_BYTE) ? PH_TAIL2_OK : PH_TAIL2_BAD;
      end
      PH_TAIL2_OK, PH_TAIL2_BAD: begin
        // tail error takes priority over checksum mismatch
        if (phase == PH_TAIL2_BAD || b != sfdc16_pkg::TAIL_BYTE) begin
          res_status = sfdc16_pkg::ST_TAIL;
        end else if ((running_crc ^ sfdc16_pkg::CRC_XOROUT) != received_crc) begin
          res_status = sfdc16_pkg::ST_CRC;
        end else begin
          res_status = sfdc16_pkg::ST_VALID;
        end
        phase_next = PH_HUNT0;
        emit       = 1'b1;
        res_kind   = sfdc16_pkg::KIND_END;
      end
      default: begin
        phase_next = (b == sfdc16_pkg::HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase
  end

  always_comb begin
    res_new.item_kind      = res_kind;
    res_new.payload_byte   = res_byte;
    res_new.sequence_id    = seq_next;
    res_new.command_code   = cmd_next;
    res_new.payload_length = len_next;
    res_new.frame_status   = res_status;
    res_new.last_of_frame  = (res_kind == sfdc16_pkg::KIND_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= sfdc16_pkg::DEFAULT_MAX_LEN;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT0;
      held_sequence <= 16'h0000;
      held_command  <= 8'h00;
      held_length   <= 16'h0000;
      bytes_left    <= 16'h0000;
      running_crc   <= 16'h0000;
      received_crc  <= 16'h0000;
    end else if (accept) begin
      phase         <= phase_next;
      held_sequence <= seq_next;
      held_command  <= cmd_next;
      held_length   <= len_next;
      bytes_left    <= left_next;
      running_crc   <= crc_next;
      received_crc  <= rcrc_next;
    end
  end

  // two-entry output queue; head word drives the port
  assign push     = accept && emit;
  assign pop      = items.valid && items.ready;
  assign rx.ready = (q_cnt != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (q_cnt == 2'd1) begin
        q0 <= res_new;
      end else begin
        q0 <= q1;
        q1 <= res_new;
      end
    end else if (push) begin
      if (q_cnt == 2'd0) begin
        q0 <= res_new;
      end else begin
        q1 <= res_new;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

  assign items.valid          = (q_cnt != 2'd0);
  assign items.item_kind      = q0.item_kind;
  assign items.payload_byte   = q0.payload_byte;
  assign items.sequence_id    = q0.sequence_id;
  assign items.command_code   = q0.command_code;
  assign items.payload_length = q0.payload_length;
  assign items.frame_status   = q0.frame_status;
  assign items.last_of_frame  = q0.last_of_frame;

  // payload phase always has at least one byte outstanding
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != 16'h0000)
    else $error("payload phase entered with no bytes left");

  // a frame end always sends the parser back to hunting
  a_end_hunts: assert property (@(posedge clk) disable iff (rst)
    push && res_new.last_of_frame |=> phase == PH_HUNT0)
    else $error("frame end did not return to hunting");

  // payload words come only from the payload phase
  a_payload_src: assert property (@(posedge clk) disable iff (rst)
    push && res_new.item_kind == sfdc16_pkg::KIND_PAYLOAD |-> phase == PH_PAYLOAD)
    else $error("payload word outside payload phase");

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt == 2'd2 && !pop |=> q_cnt == 2'd2)
    else $error("output queue lost a word");

endmodule
